// ----- hdl/dc_pi_phase_sync_macros.svh -----
// Assertion macros for the dc_pi_phase_sync block.
// Included by the top level; no other dependencies.
`ifndef DC_PI_PHASE_SYNC_MACROS_SVH
`define DC_PI_PHASE_SYNC_MACROS_SVH

`ifndef NO_ASSERTIONS
`define DCPS_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define DCPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DCPS_ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define DCPS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- hdl/dcps_pkg.sv -----
// Shared types and constants for the dc_pi_phase_sync block.
// No dependencies.
package dcps_pkg;

   localparam int RefWidth    = 63;
   localparam int MagWidth    = 64;
   localparam int CycleWidth  = 30;
   localparam int ErrWidth    = 32;
   localparam int AdjWidth    = 34;
   localparam int GainWidth   = 15;
   localparam int QshWidth    = 4;
   localparam int CountWidth  = 6;
   localparam int AddrWidth   = 5;
   localparam int ReqDataWidth = 64;
   localparam int RspDataWidth = 72;

   // register indexes (byte address bits [4:2])
   localparam logic [2:0] REG_CYCLE_NS = 3'd0;
   localparam logic [2:0] REG_SHIFT_NS = 3'd1;
   localparam logic [2:0] REG_KP_GAIN  = 3'd2;
   localparam logic [2:0] REG_KP_SHIFT = 3'd3;
   localparam logic [2:0] REG_KI_GAIN  = 3'd4;
   localparam logic [2:0] REG_KI_SHIFT = 3'd5;

   localparam logic [CycleWidth-1:0] CYCLE_NS_RESET = 30'd1000000;
   localparam logic [ErrWidth-1:0]   SHIFT_NS_RESET = 32'd0;
   localparam logic [GainWidth-1:0]  KP_GAIN_RESET  = 15'd3276;
   localparam logic [QshWidth-1:0]   KP_SHIFT_RESET = 4'd15;
   localparam logic [GainWidth-1:0]  KI_GAIN_RESET  = 15'd32;
   localparam logic [QshWidth-1:0]   KI_SHIFT_RESET = 4'd15;

   typedef struct packed {
      logic [CycleWidth-1:0] cycle_ns;
      logic [ErrWidth-1:0]   shift_ns;
      logic [GainWidth-1:0]  kp_gain;
      logic [QshWidth-1:0]   kp_shift;
      logic [GainWidth-1:0]  ki_gain;
      logic [QshWidth-1:0]   ki_shift;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic err_calc;
      logic mul;
      logic inc;
      logic acc;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

// ----- hdl/dcps_csr.sv -----
// Configuration register file of the dc_pi_phase_sync block, APB-style access.
// Depends on dcps_pkg.
module dcps_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [dcps_pkg::AddrWidth-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   output dcps_pkg::cfg_type              cfg
);

   dcps_pkg::cfg_type cfg_ff, cfg_in;
   logic       wr_en;
   logic [2:0] idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = paddr[4:2];
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            dcps_pkg::REG_CYCLE_NS: cfg_in.cycle_ns = pwdata[dcps_pkg::CycleWidth-1:0];
            dcps_pkg::REG_SHIFT_NS: cfg_in.shift_ns = pwdata;
            dcps_pkg::REG_KP_GAIN:  cfg_in.kp_gain  = pwdata[dcps_pkg::GainWidth-1:0];
            dcps_pkg::REG_KP_SHIFT: cfg_in.kp_shift = pwdata[dcps_pkg::QshWidth-1:0];
            dcps_pkg::REG_KI_GAIN:  cfg_in.ki_gain  = pwdata[dcps_pkg::GainWidth-1:0];
            dcps_pkg::REG_KI_SHIFT: cfg_in.ki_shift = pwdata[dcps_pkg::QshWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         dcps_pkg::REG_CYCLE_NS: prdata = {2'd0, cfg_ff.cycle_ns};
         dcps_pkg::REG_SHIFT_NS: prdata = cfg_ff.shift_ns;
         dcps_pkg::REG_KP_GAIN:  prdata = {17'd0, cfg_ff.kp_gain};
         dcps_pkg::REG_KP_SHIFT: prdata = {28'd0, cfg_ff.kp_shift};
         dcps_pkg::REG_KI_GAIN:  prdata = {17'd0, cfg_ff.ki_gain};
         dcps_pkg::REG_KI_SHIFT: prdata = {28'd0, cfg_ff.ki_shift};
         default:                prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cycle_ns <= dcps_pkg::CYCLE_NS_RESET;
         cfg_ff.shift_ns <= dcps_pkg::SHIFT_NS_RESET;
         cfg_ff.kp_gain  <= dcps_pkg::KP_GAIN_RESET;
         cfg_ff.kp_shift <= dcps_pkg::KP_SHIFT_RESET;
         cfg_ff.ki_gain  <= dcps_pkg::KI_GAIN_RESET;
         cfg_ff.ki_shift <= dcps_pkg::KI_SHIFT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- hdl/dcps_dp.sv -----
// Datapath of the dc_pi_phase_sync block: offset subtract, bit-serial remainder,
// phase wrap, PI multiplies, integral and output register. Depends on dcps_pkg.
module dcps_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  dcps_pkg::cfg_type                 cfg,
   input  dcps_pkg::cmd_type                 cmd,
   input  logic [dcps_pkg::RefWidth-1:0]     ref_time,
   output dcps_pkg::status_type              status,
   output logic [dcps_pkg::AdjWidth-1:0]     adjust_ns,
   output logic [dcps_pkg::ErrWidth-1:0]     phase_err
);

   localparam int MW = dcps_pkg::MagWidth;
   localparam int CW = dcps_pkg::CycleWidth;
   localparam int EW = dcps_pkg::ErrWidth;
   localparam int AW = dcps_pkg::AdjWidth;

   logic [MW-1:0] quo_ff, quo_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] rem_ff, rem_in;
   logic [dcps_pkg::CountWidth-1:0] cnt_ff, cnt_in;
   logic [EW-1:0] err_ff, err_in;
   logic [EW-1:0] p_ff, p_in;
   logic [EW-1:0] sum_ff, sum_in;
   logic [EW-1:0] inc_ff, inc_in;
   logic [EW-1:0] acc_ff, acc_in;
   logic [EW-1:0] prev_ff, prev_in;
   logic [AW-1:0] adj_ff, adj_in;
   logic [EW-1:0] perr_ff, perr_in;

   logic [MW-1:0] ref_ext, shift_abs;
   logic [EW-1:0] trial;
   logic [EW-1:0] p_sh, acc_sh;

   assign ref_ext   = {1'b0, ref_time};
   assign shift_abs = cfg.shift_ns[EW-1] ? {32'd0, (~cfg.shift_ns) + 32'd1}
                                          : {32'd0, cfg.shift_ns};
   // one restoring step: shift in the next dividend bit, subtract if it fits
   assign trial  = {1'b0, rem_ff, quo_ff[MW-1]} - {2'b00, cfg.cycle_ns};
   assign p_sh   = EW'($signed(p_ff) >>> cfg.kp_shift);
   assign acc_sh = EW'($signed(acc_ff) >>> cfg.ki_shift);
   assign status.div_last = (cnt_ff == {dcps_pkg::CountWidth{1'b1}});

   always_comb begin
      quo_in = quo_ff;
      neg_in = neg_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         cnt_in = '0;
         rem_in = '0;
         if (cfg.shift_ns[EW-1]) begin
            quo_in = ref_ext + shift_abs;
            neg_in = 1'b0;
         end else if (ref_ext >= shift_abs) begin
            quo_in = ref_ext - shift_abs;
            neg_in = 1'b0;
         end else begin
            quo_in = shift_abs - ref_ext;
            neg_in = 1'b1;
         end
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[MW-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (!trial[EW-1]) begin
            rem_in = trial[CW-1:0];
         end else begin
            rem_in = {rem_ff[CW-2:0], quo_ff[MW-1]};
         end
      end
   end

   always_comb begin
      err_in = err_ff;
      if (cmd.err_calc) begin
         if (cfg.cycle_ns == '0) begin
            err_in = '0;
         end else if (neg_ff) begin
            err_in = 32'd0 - {2'b00, rem_ff};
         end else if (rem_ff > (cfg.cycle_ns >> 1)) begin
            err_in = {2'b00, rem_ff} - {2'b00, cfg.cycle_ns};
         end else begin
            err_in = {2'b00, rem_ff};
         end
      end
   end

   always_comb begin
      p_in    = p_ff;
      sum_in  = sum_ff;
      inc_in  = inc_ff;
      acc_in  = acc_ff;
      prev_in = prev_ff;
      adj_in  = adj_ff;
      perr_in = perr_ff;
      if (cmd.mul) begin
         p_in   = err_ff * {17'd0, cfg.kp_gain};
         sum_in = err_ff + prev_ff;
      end
      if (cmd.inc) begin
         inc_in = sum_ff * {17'd0, cfg.ki_gain};
      end
      if (cmd.acc) begin
         acc_in  = acc_ff + inc_ff;
         prev_in = err_ff;
      end
      if (cmd.out_load) begin
         adj_in  = 34'd0 - {{2{p_sh[EW-1]}}, p_sh} - {{2{acc_sh[EW-1]}}, acc_sh};
         perr_in = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         prev_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         prev_ff <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      err_ff  <= err_in;
      p_ff    <= p_in;
      sum_ff  <= sum_in;
      inc_ff  <= inc_in;
      adj_ff  <= adj_in;
      perr_ff <= perr_in;
   end

   assign adjust_ns = adj_ff;
   assign phase_err = perr_ff;

endmodule

// ----- hdl/dcps_ctrl.sv -----
// Sequencer of the dc_pi_phase_sync block: steps the datapath through one word
// and owns the result valid flag. Depends on dcps_pkg.
module dcps_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  dcps_pkg::status_type status,
   output dcps_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_ERR  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_INC  = 3'd4;
   localparam logic [2:0] ST_ACC  = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      valid_in = valid_ff & ~rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            cmd.err_calc = 1'b1;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_INC;
         end
         ST_INC: begin
            cmd.inc  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               valid_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ----- hdl/dc_pi_phase_sync.sv -----
// rsp_tvalid rises once the accepted req word has passed the 64-step bit-serial
// remainder unit and the error, multiply, integral and output steps; no new word
// is accepted until the result is loaded into the output register.
// Reset (synchronous, active high): registers to defaults, integral and previous
// error to zero, no result pending. Depends on dcps_pkg, dcps_csr, dcps_ctrl, dcps_dp.
`include "dc_pi_phase_sync_macros.svh"

module dc_pi_phase_sync (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dcps_pkg::ReqDataWidth-1:0] req_tdata,  // [62:0] ref_time
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dcps_pkg::RspDataWidth-1:0] rsp_tdata,  // [33:0] adjust_ns, [65:34] phase_err
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [dcps_pkg::AddrWidth-1:0]    csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   dcps_pkg::cfg_type    cfg;
   dcps_pkg::cmd_type    cmd;
   dcps_pkg::status_type status;
   logic [dcps_pkg::AdjWidth-1:0] adjust_ns;
   logic [dcps_pkg::ErrWidth-1:0] phase_err;

   dcps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   dcps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   dcps_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .ref_time  (req_tdata[dcps_pkg::RefWidth-1:0]),
      .status    (status),
      .adjust_ns (adjust_ns),
      .phase_err (phase_err)
   );

   assign rsp_tdata = {6'd0, phase_err, adjust_ns};

   `DCPS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "accepted a word while busy")
   `DCPS_ASSERT_ALWAYS(a_cmd_onehot, clock, reset, $onehot0(cmd), "more than one datapath command")
   `DCPS_ASSERT_ALWAYS(a_result_from_busy, clock, reset, !$rose(rsp_tvalid) || $past(!req_tready), "result without work")

endmodule

// ----- tb/tb_dc_pi_phase_sync.sv -----
// Self-checking bench for dc_pi_phase_sync: streams reference times, predicts each
// correction and phase error in-line and compares every result word.
// Depends on dcps_pkg and the dc_pi_phase_sync RTL.
module tb_dc_pi_phase_sync;
   import dcps_pkg::*;

   typedef struct packed {
      logic [AdjWidth-1:0] adjust;
      logic [ErrWidth-1:0] phase;
   } correction_t;

   typedef enum int {IDLE_BOTH, IDLE_NONE, IDLE_SEND_ONLY, IDLE_RECV_ONLY} idle_mode_t;

   localparam int HoldCycles = 400;
   localparam int TailCycles = 80;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;   // [62:0] ref_time
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;        // [33:0] adjust_ns, [65:34] phase_err
   logic                    csr_psel = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite = 1'b0;
   logic [AddrWidth-1:0]    csr_paddr = '0;
   logic [31:0]             csr_pwdata = '0;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   // predictor copy of the registers and loop state
   cfg_type                 cfg;
   logic [ErrWidth-1:0]     integ_acc;
   logic [ErrWidth-1:0]     last_err;

   logic [62:0]             pending_refs[$];
   correction_t             due_corrections[$];
   idle_mode_t              idle_mode = IDLE_BOTH;
   logic [63:0]             sync_time;

   int                      words_queued = 0;
   int                      words_sent = 0;
   int                      results_checked = 0;
   int                      mismatches = 0;
   int                      settings_used = 0;
   int                      send_gap = 0;
   int                      recv_gap = 0;
   int                      hold_left = 0;
   logic                    hold_start = 1'b0;
   correction_t             want;

   dc_pi_phase_sync DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   function automatic logic [AdjWidth-1:0] shifted_term(input logic [31:0] v,
                                                        input logic [3:0] sh);
      logic signed [31:0] s;
      s = $signed(v) >>> sh;
      return {{2{s[31]}}, s};
   endfunction

   // advance the loop state by one reference time and return what the block must send
   function automatic correction_t predict_correction(input logic [62:0] ref_ns);
      logic [63:0]         mag;
      logic                below;
      logic [29:0]         rem;
      logic [ErrWidth-1:0] err;
      logic [ErrWidth-1:0] prop;
      correction_t         c;
      below = 1'b0;
      if (cfg.shift_ns[31]) begin
         mag = {1'b0, ref_ns} + {32'd0, 32'd0 - cfg.shift_ns};
      end else if ({1'b0, ref_ns} >= {32'd0, cfg.shift_ns}) begin
         mag = {1'b0, ref_ns} - {32'd0, cfg.shift_ns};
      end else begin
         mag = {32'd0, cfg.shift_ns} - {1'b0, ref_ns};
         below = 1'b1;
      end
      if (cfg.cycle_ns == '0) begin
         err = '0;
      end else begin
         rem = 30'(mag % {34'd0, cfg.cycle_ns});
         if (below) begin
            err = 32'd0 - {2'b00, rem};
         end else if (rem > cfg.cycle_ns / 2) begin
            err = {2'b00, rem} - {2'b00, cfg.cycle_ns};
         end else begin
            err = {2'b00, rem};
         end
      end
      prop = err * {17'd0, cfg.kp_gain};
      integ_acc = integ_acc + (err + last_err) * {17'd0, cfg.ki_gain};
      last_err = err;
      c.adjust = 34'd0 - shifted_term(prop, cfg.kp_shift) - shifted_term(integ_acc, cfg.ki_shift);
      c.phase = err;
      return c;
   endfunction

   function automatic int draw_send_gap();
      return (idle_mode == IDLE_BOTH || idle_mode == IDLE_SEND_ONLY) ? $urandom_range(0, 8) : 0;
   endfunction

   function automatic int draw_recv_gap();
      return (idle_mode == IDLE_BOTH || idle_mode == IDLE_RECV_ONLY) ? $urandom_range(0, 8) : 0;
   endfunction

   // most often a locked loop (advancing by cycle_ns per word plus jitter), then edges around
   // the shift, half-cycle boundaries, small and fully random times
   function automatic logic [62:0] make_ref();
      logic [63:0] cyc;
      logic [63:0] sh;
      logic [63:0] val;
      logic [63:0] off;
      int          pick;
      cyc = {34'd0, cfg.cycle_ns};
      sh = {{32{cfg.shift_ns[31]}}, cfg.shift_ns};
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         sync_time = sync_time + cyc + 64'($urandom_range(0, 64)) - 64'd32;
         val = sync_time;
      end else if (pick < 65) begin
         val = {$urandom, $urandom};
      end else if (pick < 75) begin
         val = 64'($urandom) >> $urandom_range(0, 31);
      end else if (pick < 90) begin
         off = 64'($urandom) % (6 * cyc + 1);
         val = sh + off - 3 * cyc;
         if (val[63]) val = off;
      end else begin
         off = 64'($urandom_range(0, 1000)) * cyc + cyc / 2 + 64'($urandom_range(0, 2));
         val = sh + off - 64'd1;
         if (val[63]) val = off;
      end
      return val[62:0];
   endfunction

   function automatic void note_mismatch(input string what);
      mismatches++;
      if (mismatches <= 10) $display("%s", what);
   endfunction

   // sender: holds a word until taken, then waits its drawn gap
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            due_corrections.push_back(predict_correction(req_tdata[62:0]));
            words_sent++;
            send_gap = draw_send_gap();
         end
         if (send_gap == 0 && pending_refs.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= {1'b0, pending_refs.pop_front()};
         end else begin
            req_tvalid <= 1'b0;
            if (send_gap != 0) send_gap--;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) hold_left <= 0;
      else if (hold_start) hold_left <= HoldCycles;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // receiver: check each word against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_corrections.size() == 0) begin
               note_mismatch($sformatf("result word %0d with nothing expected: %h",
                                       results_checked, rsp_tdata));
            end else begin
               want = due_corrections.pop_front();
               if (rsp_tdata[33:0] !== want.adjust || rsp_tdata[65:34] !== want.phase)
                  note_mismatch($sformatf(
                     "word %0d: adjust_ns exp %0d got %0d, phase_err exp %0d got %0d",
                     results_checked, $signed(want.adjust), $signed(rsp_tdata[33:0]),
                     $signed(want.phase), $signed(rsp_tdata[65:34])));
            end
            results_checked++;
            recv_gap = draw_recv_gap();
         end
         if (hold_left != 0) begin
            rsp_tready <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_CYCLE_NS: cfg.cycle_ns = val[CycleWidth-1:0];
         REG_SHIFT_NS: cfg.shift_ns = val;
         REG_KP_GAIN:  cfg.kp_gain = val[GainWidth-1:0];
         REG_KP_SHIFT: cfg.kp_shift = val[QshWidth-1:0];
         REG_KI_GAIN:  cfg.ki_gain = val[GainWidth-1:0];
         REG_KI_SHIFT: cfg.ki_shift = val[QshWidth-1:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [31:0] cyc, input logic [31:0] sh,
                            input logic [31:0] kp, input logic [31:0] kp_sh,
                            input logic [31:0] ki, input logic [31:0] ki_sh);
      csr_write(REG_CYCLE_NS, cyc);
      csr_write(REG_SHIFT_NS, sh);
      csr_write(REG_KP_GAIN, kp);
      csr_write(REG_KP_SHIFT, kp_sh);
      csr_write(REG_KI_GAIN, ki);
      csr_write(REG_KI_SHIFT, ki_sh);
      settings_used++;
   endtask

   task automatic queue_ref(input logic [62:0] ref_ns);
      pending_refs.push_back(ref_ns);
      words_queued++;
   endtask

   task automatic queue_random(input int count);
      sync_time = {$urandom, $urandom} >> $urandom_range(1, 40);
      repeat (count) queue_ref(make_ref());
   endtask

   // hold off until every queued word is in and answered
   task automatic drain();
      wait (words_sent == words_queued && due_corrections.size() == 0);
      @(posedge clock);
   endtask

   task automatic random_setting();
      logic [31:0] cyc;
      case ($urandom_range(0, 2))
         0: cyc = $urandom_range(1, 64);
         1: cyc = $urandom_range(1, 1 << 20);
         default: cyc = $urandom_range(1, 1000000000);
      endcase
      write_all(cyc, $urandom, $urandom_range(0, 32767), $urandom_range(0, 15),
                $urandom_range(0, 32767), $urandom_range(0, 15));
   endtask

   initial begin
      cfg.cycle_ns = CYCLE_NS_RESET;
      cfg.shift_ns = SHIFT_NS_RESET;
      cfg.kp_gain = KP_GAIN_RESET;
      cfg.kp_shift = KP_SHIFT_RESET;
      cfg.ki_gain = KI_GAIN_RESET;
      cfg.ki_shift = KI_SHIFT_RESET;
      integ_acc = '0;
      last_err = '0;
      settings_used = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset values: half-cycle edges and bit patterns
      idle_mode = IDLE_BOTH;
      queue_ref(63'd0);
      queue_ref(63'd1);
      queue_ref(63'd500000);
      queue_ref(63'd500001);
      queue_ref(63'd999999);
      queue_ref(63'd1000000);
      queue_ref(63'h7FFF_FFFF_FFFF_FFFF);
      queue_ref(63'h5555_5555_5555_5555);
      queue_ref(63'h2AAA_AAAA_AAAA_AAAA);
      queue_ref(63'd12345250000);
      queue_random(150);
      drain();

      // largest cycle, most negative shift, full gains, no shift: products wrap
      idle_mode = IDLE_NONE;
      write_all(32'd1000000000, 32'h8000_0000, 32'd32767, 32'd0, 32'd32767, 32'd0);
      queue_ref(63'd0);
      queue_ref(63'h7FFF_FFFF_FFFF_FFFF);
      queue_ref(63'd1352516352);
      queue_ref(63'd1352516353);
      queue_random(200);
      drain();

      // smallest cycle, largest shift, zero gains: reference below the shift
      idle_mode = IDLE_SEND_ONLY;
      write_all(32'd1, 32'h7FFF_FFFF, 32'd0, 32'd15, 32'd0, 32'd15);
      queue_ref(63'd0);
      queue_ref(63'd2147483647);
      queue_ref(63'd2147483648);
      queue_random(100);
      drain();

      // zero cycle forces a zero error
      idle_mode = IDLE_RECV_ONLY;
      write_all(32'd0, $urandom, 32'd32767, 32'd3, 32'd32767, 32'd2);
      queue_ref(63'd12345);
      queue_ref(63'h7FFF_FFFF_FFFF_FFFF);
      queue_random(60);
      drain();

      // long output stall while words keep coming
      idle_mode = IDLE_NONE;
      random_setting();
      @(posedge clock);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      queue_random(205);
      drain();

      // pause the sender mid-stream until everything is back
      idle_mode = IDLE_BOTH;
      random_setting();
      queue_random(100);
      drain();
      queue_random(105);
      drain();

      for (int p = 0; p < 3; p++) begin
         idle_mode = idle_mode_t'(p == 1 ? IDLE_NONE : IDLE_BOTH);
         random_setting();
         queue_random(205);
         drain();
      end

      repeat (TailCycles) @(posedge clock);
      if (due_corrections.size() != 0)
         note_mismatch($sformatf("%0d results never arrived", due_corrections.size()));
      $display("%0d reference times checked over %0d register settings,", results_checked,
               settings_used);
      $display("with zero cycle, extreme gains and shifts, a long output stall and a pause");
      if (mismatches == 0) begin
         $display("tb_dc_pi_phase_sync: clean");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb_dc_pi_phase_sync: errors");
      end
      $finish;
   end

   initial begin
      #6000000;
      $display("timeout waiting for results");
      $display("tb_dc_pi_phase_sync: errors");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/dcps_pkg.sv
hdl/dcps_csr.sv
hdl/dcps_dp.sv
hdl/dcps_ctrl.sv
hdl/dc_pi_phase_sync.sv
tb/tb_dc_pi_phase_sync.sv
